/* rtl/fsir_pkg.sv */
// shared types and constants for the first-seen index renumbering block
// no dependencies; imported by the top level

package fsir_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 65536;
  localparam int unsigned DEF_INDEX_BITS  = 16;

  localparam int unsigned GIDX_W   = 16;
  localparam int unsigned LID_W    = 16;
  localparam int unsigned UCNT_W   = 17;
  localparam int unsigned MAXIDX_W = 17;

  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 88;

  typedef enum logic {
    OP_MAP   = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_LOOKUP = 3'b100
  } state_e;

endpackage

/* rtl/fsir_ram.sv */
// generic single-clock ram, one write port and one read port, registered read
// no dependencies; used for the forward and reverse tables

module fsir_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/first_seen_index_renumber.sv */
// top level of the first-seen index renumbering block
// depends on fsir_pkg and fsir_ram

// Renumbers global node indices into dense local ids in order of first
// appearance, and answers reverse queries from local id to global index.
// After reset the forward table is swept to zero, one entry per cycle; no
// transfer is accepted until the sweep ends. An item is accepted in ST_IDLE,
// which issues the table reads, and ST_LOOKUP then uses the registered read
// data and writes the tables for a new index once the output register is
// free; no item is accepted in ST_LOOKUP. Results sit in an output register,
// so a new item is accepted while the previous result still waits.

module first_seen_index_renumber #(
  parameter int unsigned TABLE_DEPTH = fsir_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned INDEX_BITS  = fsir_pkg::DEF_INDEX_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] global_index, [31:16] local_query
  input  logic [fsir_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // opcode
  input  logic                           s_axis_tuser,
  // end_of_list
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] local_id, [16] is_new, [32:17] found_global, [33] query_valid,
  // [50:34] unique_count, [66:51] min_index, [83:67] max_index, rest zero
  output logic [fsir_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // list_done
  output logic                           m_axis_tlast
);

  import fsir_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [GIDX_W-1:0] IDX_MASK = GIDX_W'((32'd1 << INDEX_BITS) - 32'd1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

  state_e state_q, state_d;
  logic [AW-1:0] clr_q;

  logic                       op_q;
  logic [GIDX_W-1:0]          gidx_q;
  logic [LID_W-1:0]           lq_q;
  logic                       eol_q;
  logic                       in_range_q;

  logic [CW-1:0]              count_q, count_d;
  logic [GIDX_W-1:0]          min_q, min_d;
  logic signed [MAXIDX_W-1:0] max_q, max_d;

  logic                       out_valid_q;
  logic [M_TDATA_W-1:0]       out_data_q;
  logic                       out_last_q;

  logic              accept;
  logic              advance;
  logic [GIDX_W-1:0] gidx_in;
  logic [31:0]       gidx_in_w;
  logic [31:0]       lq_in_w;
  logic [31:0]       gidx_w;
  logic [31:0]       count_w;
  logic [31:0]       count_d_w;
  logic [31:0]       lid_w;

  logic              fwd_we;
  logic [AW-1:0]     fwd_waddr;
  logic [CW-1:0]     fwd_wdata;
  logic [CW-1:0]     fwd_rdata;
  logic              rev_we;
  logic [GIDX_W-1:0] rev_rdata;

  logic              is_map;
  logic              hit_new;
  logic              qv;
  logic [GIDX_W-1:0] found;
  logic [M_TDATA_W-1:0] result;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign advance   = (state_q == ST_LOOKUP) && (!out_valid_q || m_axis_tready);
  assign gidx_in   = s_axis_tdata[GIDX_W-1:0] & IDX_MASK;
  assign gidx_in_w = 32'(gidx_in);
  assign lq_in_w   = 32'(s_axis_tdata[S_TDATA_W-1:GIDX_W]);
  assign gidx_w    = 32'(gidx_q);
  assign count_w   = 32'(count_q);

  assign s_axis_tready = (state_q == ST_IDLE);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_ADDR) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (advance) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= s_axis_tuser;
      gidx_q     <= gidx_in;
      lq_q       <= s_axis_tdata[S_TDATA_W-1:GIDX_W];
      eol_q      <= s_axis_tlast;
      in_range_q <= (gidx_in_w < TABLE_DEPTH);
    end
  end

  // lookup and update
  assign is_map  = (op_q == OP_MAP);
  assign hit_new = is_map && in_range_q && (fwd_rdata == '0);
  assign qv      = !is_map && (32'(lq_q) < count_w) && (32'(lq_q) < TABLE_DEPTH);
  assign found   = qv ? rev_rdata : '0;

  always_comb begin
    lid_w = '0;
    if (is_map && in_range_q) begin
      lid_w = hit_new ? count_w : (32'(fwd_rdata) - 32'd1);
    end
  end

  always_comb begin
    count_d = count_q;
    min_d   = min_q;
    max_d   = max_q;
    if (hit_new) begin
      count_d = count_q + 1'b1;
      if (gidx_q < min_q) min_d = gidx_q;
      if ($signed({1'b0, gidx_q}) > max_q) max_d = $signed({1'b0, gidx_q});
    end
  end

  assign count_d_w = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= IDX_MASK;
      max_q   <= '1;
    end else if (advance) begin
      count_q <= count_d;
      min_q   <= min_d;
      max_q   <= max_d;
    end
  end

  // tables
  assign fwd_we    = (state_q == ST_CLEAR) || (advance && hit_new);
  assign fwd_waddr = (state_q == ST_CLEAR) ? clr_q : gidx_w[AW-1:0];
  assign fwd_wdata = (state_q == ST_CLEAR) ? '0 : count_d;
  assign rev_we    = advance && hit_new;

  fsir_ram #(
    .WIDTH (CW),
    .DEPTH (TABLE_DEPTH)
  ) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .re_i    (accept),
    .raddr_i (gidx_in_w[AW-1:0]),
    .rdata_o (fwd_rdata)
  );

  fsir_ram #(
    .WIDTH (GIDX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_rev_ram (
    .clk_i   (clk_i),
    .we_i    (rev_we),
    .waddr_i (count_w[AW-1:0]),
    .wdata_i (gidx_q),
    .re_i    (accept),
    .raddr_i (lq_in_w[AW-1:0]),
    .rdata_o (rev_rdata)
  );

  // output register
  assign result = M_TDATA_W'({max_d, min_d, count_d_w[UCNT_W-1:0], qv, found,
                              hit_new, lid_w[LID_W-1:0]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
      out_last_q <= eol_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  a_new_id_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[16]) |->
      (m_axis_tdata[15:0] == 16'(m_axis_tdata[50:34] - 17'd1)))
    else $error("new id does not match count");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && hit_new) |=> (count_q == $past(count_q) + 1'b1))
    else $error("count did not step on a new index");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !hit_new) |=> $stable(count_q))
    else $error("count changed without a new index");

  a_query_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[33]) |->
      (!m_axis_tdata[16] && (m_axis_tdata[15:0] == '0)))
    else $error("query result carries map fields");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_w <= TABLE_DEPTH))
    else $error("count beyond table depth");
`endif

endmodule
